>>> rtl/core/tkhd_pkg.sv
// shared constants, types and control structs for the top-k degree selector
package tkhd_pkg;

    localparam int MAX_KEEP = 16;
    localparam int DEG_W    = 32;
    localparam int ID_W     = 32;
    localparam int LIMIT_W  = 5;
    localparam int CNT_W    = $clog2(MAX_KEEP + 1);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);

    // one kept entry
    typedef struct packed {
        logic [DEG_W-1:0] degree;
        logic [ID_W-1:0]  id;
    } entry_t;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic load;       // insert the offer into the sorted row
        logic shift_out;  // move every entry one place toward cell 0
    } cell_ctrl_t;

endpackage

>>> rtl/core/tkhd_stream_if.sv
// valid/ready stream interfaces for offers and kept entries
interface tkhd_offer_if;
    logic                        valid;
    logic                        ready;
    logic [tkhd_pkg::DEG_W-1:0]  node_degree;
    logic [tkhd_pkg::ID_W-1:0]   node_id;
    logic                        offer_last;

    modport source (output valid, node_degree, node_id, offer_last, input ready);
    modport sink   (input valid, node_degree, node_id, offer_last, output ready);
endinterface

interface tkhd_kept_if;
    logic                        valid;
    logic                        ready;
    logic [tkhd_pkg::DEG_W-1:0]  kept_degree_out;
    logic [tkhd_pkg::ID_W-1:0]   kept_id_out;
    logic                        readout_last;

    modport source (output valid, kept_degree_out, kept_id_out, readout_last, input ready);
    modport sink   (input valid, kept_degree_out, kept_id_out, readout_last, output ready);
endinterface

>>> rtl/core/top_k_highest_degree_select.sv
// top level: sorted cell row, fill count and readout control for top-k selection
//
//  channel   dir  signals                                      transfer
//  offer     in   node_degree, node_id, offer_last             valid & ready
//  kept      out  kept_degree_out, kept_id_out, readout_last   valid & ready
//  cfg       in   cfg_we, cfg_wdata (keep_limit)               cfg_we
//
//  one offer is taken every cycle outside readout: a parallel compare over all cells and a one-place
//  shift insert it in the cycle it transfers.
//  after a last offer the block sends the held entries, one per cycle, highest first;
//  offer.ready is low until the last held entry is sent (entries held: 1 to MAX_KEEP).
//  a stalled kept channel holds the head entry and stretches the readout.
//  reset empties the row and sets keep_limit to 10; cell contents are not cleared.
module top_k_highest_degree_select (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tkhd_pkg::LIMIT_W-1:0]  cfg_wdata,
    tkhd_offer_if.sink                    offer,
    tkhd_kept_if.source                   kept
);

    localparam int N = tkhd_pkg::MAX_KEEP;
    localparam int W = tkhd_pkg::CNT_W;

    logic [tkhd_pkg::LIMIT_W-1:0] limit_reg;
    logic [W-1:0]                 count_reg;
    logic [W-1:0]                 count_next;
    logic                         readout_reg;
    logic                         readout_next;

    logic [W-1:0]                 eff_limit;
    logic                         offer_xfer;
    logic                         kept_xfer;
    logic                         below_limit;
    logic                         beats_held;
    logic                         do_insert;
    tkhd_pkg::cell_ctrl_t         ctrl;
    tkhd_pkg::entry_t             offer_entry;

    logic                         held     [N];
    logic                         ge       [N];
    logic                         prev_ge  [N];
    tkhd_pkg::entry_t             cell_q   [N];
    tkhd_pkg::entry_t             prev_e   [N];
    tkhd_pkg::entry_t             next_e   [N];

    // handshakes
    assign offer.ready = !readout_reg;
    assign offer_xfer  = offer.valid && offer.ready;
    assign kept_xfer   = kept.valid && kept.ready;

    // limit of zero acts as one, above capacity saturates
    always_comb
    begin
        if (limit_reg == '0)
            eff_limit = W'(1);
        else if (32'(limit_reg) > N)
            eff_limit = W'(N);
        else
            eff_limit = W'(limit_reg);
    end

    assign offer_entry.degree = offer.node_degree;
    assign offer_entry.id     = offer.node_id;

    // neighbor wiring along the row
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            held[i] = (count_reg > W'(i));
            if (i == 0)
            begin
                prev_ge[i] = 1'b1;
                prev_e[i]  = offer_entry;
            end
            else
            begin
                prev_ge[i] = ge[i-1];
                prev_e[i]  = cell_q[i-1];
            end
            if (i == N - 1)
                next_e[i] = cell_q[i];
            else
                next_e[i] = cell_q[i+1];
        end
    end

    // offer beats the lowest held entry when any held cell ranks below it
    always_comb
    begin
        beats_held = 1'b0;
        for (int i = 0; i < N; i++)
            beats_held = beats_held || (held[i] && !ge[i]);
    end

    assign below_limit = (count_reg < eff_limit);
    assign do_insert   = below_limit || beats_held;
    assign ctrl.load      = offer_xfer && do_insert;
    assign ctrl.shift_out = kept_xfer;

    // cell row
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        tkhd_cell u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .offer_degree (offer.node_degree),
            .offer_entry  (offer_entry),
            .held         (held[g]),
            .prev_ge      (prev_ge[g]),
            .prev_entry   (prev_e[g]),
            .next_entry   (next_e[g]),
            .ge           (ge[g]),
            .entry        (cell_q[g])
        );
    end

    // fill count and readout mode
    always_comb
    begin
        count_next   = count_reg;
        readout_next = readout_reg;
        if (offer_xfer)
        begin
            if (below_limit)
                count_next = count_reg + W'(1);
            if (offer.offer_last)
                readout_next = 1'b1;
        end
        else if (kept_xfer)
        begin
            count_next = count_reg - W'(1);
            if (count_reg == W'(1))
                readout_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= tkhd_pkg::LIMIT_RESET;
            count_reg   <= '0;
            readout_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            count_reg   <= count_next;
            readout_reg <= readout_next;
        end
    end

    // the head cell drives the readout
    assign kept.valid           = readout_reg;
    assign kept.kept_degree_out = cell_q[0].degree;
    assign kept.kept_id_out     = cell_q[0].id;
    assign kept.readout_last    = (count_reg == W'(1));

endmodule

>>> rtl/core/tkhd_cell.sv
// one cell of the sorted entry row: compare against the offer, hold, load or shift
module tkhd_cell (
    input  logic                        clk,
    input  tkhd_pkg::cell_ctrl_t        ctrl,
    input  logic [tkhd_pkg::DEG_W-1:0]  offer_degree,
    input  tkhd_pkg::entry_t            offer_entry,
    input  logic                        held,
    input  logic                        prev_ge,
    input  tkhd_pkg::entry_t            prev_entry,
    input  tkhd_pkg::entry_t            next_entry,
    output logic                        ge,
    output tkhd_pkg::entry_t            entry
);

    tkhd_pkg::entry_t entry_reg;
    tkhd_pkg::entry_t entry_next;

    // held entry ranks at or above the offer (earlier arrival wins ties)
    assign ge    = held && (entry_reg.degree >= offer_degree);
    assign entry = entry_reg;

    // insert: keep if ranking at or above, take offer at the boundary, else shift down; shift_out takes the next entry
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load)
        begin
            if (ge)
                entry_next = entry_reg;
            else if (prev_ge)
                entry_next = offer_entry;
            else
                entry_next = prev_entry;
        end
        else if (ctrl.shift_out)
        begin
            entry_next = next_entry;
        end
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
